/* design/rrss_pkg.sv */
// Shared types and constants for the round robin sleep scheduler.
`default_nettype none

package rrss_pkg;

    // Operation codes carried by an input item
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_SLEEP = 2'd2,
        OP_SCHED = 2'd3
    } op_t;

    // Per-slot task status codes
    typedef enum logic [1:0] {
        ST_RUNNABLE = 2'd0,
        ST_SLEEP    = 2'd1,
        ST_EXITED   = 2'd2,
        ST_RUNNING  = 2'd3
    } status_t;

    // Milliseconds per second, and the width of seconds times that factor
    localparam logic [9:0] MS_PER_S = 10'd1000;
    localparam int         SECS_W   = 16;
    localparam int         PROD_W   = 26;

    // Input item
    typedef struct packed {
        op_t               operation;
        logic [3:0]        slot;
        logic [SECS_W-1:0] sleep_seconds;
    } req_t;

    // Result item
    typedef struct packed {
        logic       found;
        logic [3:0] next_slot;
    } rsp_t;

endpackage

`default_nettype wire

/* design/rrss_time_unit.sv */
// Time arithmetic unit: sleep product register, wake time adder and due compare.
`default_nettype none

module rrss_time_unit
    import rrss_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 mul_load,
    input  wire logic [SECS_W-1:0]    seconds,
    input  wire logic [TIME_BITS-1:0] now_ms,
    input  wire logic [TIME_BITS-1:0] cmp_time,
    output logic      [TIME_BITS-1:0] wake_sum,
    output logic                      due
);

    localparam int SUM_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;

    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum;

    // Hold seconds times 1000 for the following write cycle
    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            prod_reg <= PROD_W'(seconds) * PROD_W'(MS_PER_S);
        end
    end

    // Wake time wraps at the clock width
    assign sum      = SUM_W'(now_ms) + SUM_W'(prod_reg);
    assign wake_sum = sum[TIME_BITS-1:0];

    // A sleeper is due when its wake time lies strictly before now
    assign due = (now_ms > cmp_time);

endmodule

`default_nettype wire

/* design/round_robin_sleep_scheduler.sv */
// Round robin task scheduler with millisecond sleeps: sequencer and slot table.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_t (operation, slot, sleep_seconds)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t (found, next_slot)
//
// Tick and add go to S_DONE, which loads the result once the output is free.
// Schedule runs a wake pass, then a search; sleep runs S_WRITE first. The wake pass
// reads the wake time memory one slot a cycle, then the search checks one slot a cycle.
// rst_n clears the slot table to slot 0 present, all runnable; wake times stay
// unwritten. A new item is taken while a previous result still waits on rsp_stall.
`default_nettype none

module round_robin_sleep_scheduler
    import rrss_pkg::*;
#(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int                SLOT_W     = $clog2(TASK_SLOTS);
    localparam int                IDX_W      = $clog2(TASK_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0]  SLOT_COUNT = IDX_W'(TASK_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WRITE  = 5'b00010,
        S_WAKE   = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      cur_slot_reg, cur_slot_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TASK_SLOTS-1:0]  present_reg, present_next;
    status_t                status_reg [TASK_SLOTS];
    status_t                status_next [TASK_SLOTS];
    logic                   found_reg, found_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       wake_idx_reg, wake_idx_next;
    logic [SLOT_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [SLOT_W-1:0]      srch_idx_reg, srch_idx_next;
    logic [SLOT_W-1:0]      srch_cnt_reg, srch_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic [TIME_BITS-1:0]   wake_mem [TASK_SLOTS];
    logic [TIME_BITS-1:0]   wake_rd_reg;

    logic                   req_acc;
    logic                   rsp_free;
    logic                   mul_load;
    logic                   wake_wr;
    logic                   wake_rd;
    logic [TIME_BITS-1:0]   wake_sum;
    logic                   due;
    logic                   slot_ok;
    logic [SLOT_W+3:0]      slot_ext;
    logic [SLOT_W-1:0]      add_idx;
    logic [SLOT_W+3:0]      cur_ext;
    logic [SLOT_W-1:0]      sel_idx;
    logic                   sel_present;
    status_t                sel_status;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == LAST_SLOT)
        begin
            return '0;
        end
        return s + SLOT_W'(1);
    endfunction

    // Handshakes
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Decode the add slot and the reported slot
    assign slot_ok  = (int'(req.slot) < TASK_SLOTS);
    assign slot_ext = {SLOT_W'(0), req.slot};
    assign add_idx  = slot_ext[SLOT_W-1:0];
    assign cur_ext  = {4'b0000, cur_slot_reg};

    // One table read port, shared by the wake pass and the search
    assign sel_idx     = (state_reg == S_SEARCH) ? srch_idx_reg : chk_idx_reg;
    assign sel_present = present_reg[sel_idx];
    assign sel_status  = status_reg[sel_idx];

    rrss_time_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_time (
        .clk      (clk),
        .mul_load (mul_load),
        .seconds  (req.sleep_seconds),
        .now_ms   (now_reg),
        .cmp_time (wake_rd_reg),
        .wake_sum (wake_sum),
        .due      (due)
    );

    // Wake time memory: one write at the current slot, one registered read
    always_ff @(posedge clk)
    begin
        if (wake_wr)
        begin
            wake_mem[cur_slot_reg] <= wake_sum;
        end
        if (wake_rd)
        begin
            wake_rd_reg <= wake_mem[wake_idx_reg[SLOT_W-1:0]];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_slot_next  = cur_slot_reg;
        now_next       = now_reg;
        present_next   = present_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        chk_vld_next   = chk_vld_reg;
        wake_idx_next  = wake_idx_reg;
        chk_idx_next   = chk_idx_reg;
        srch_idx_next  = srch_idx_reg;
        srch_cnt_next  = srch_cnt_reg;
        mul_load       = 1'b0;
        wake_wr        = 1'b0;
        wake_rd        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    found_next = 1'b0;
                    unique case (req.operation)
                        OP_TICK:
                        begin
                            now_next   = now_reg + TIME_BITS'(1);
                            state_next = S_DONE;
                        end
                        OP_ADD:
                        begin
                            if (slot_ok)
                            begin
                                present_next[add_idx] = 1'b1;
                                status_next[add_idx]  = ST_RUNNABLE;
                            end
                            state_next = S_DONE;
                        end
                        OP_SLEEP:
                        begin
                            mul_load   = 1'b1;
                            state_next = S_WRITE;
                        end
                        OP_SCHED:
                        begin
                            wake_idx_next = '0;
                            chk_vld_next  = 1'b0;
                            state_next    = S_WAKE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                // Store the wake time and put the current task to sleep
                wake_wr                     = 1'b1;
                status_next[cur_slot_reg]   = ST_SLEEP;
                wake_idx_next               = '0;
                chk_vld_next                = 1'b0;
                state_next                  = S_WAKE;
            end
            S_WAKE:
            begin
                // Wake the slot whose wake time was read last cycle
                if (chk_vld_reg && sel_present && (sel_status == ST_SLEEP) && due)
                begin
                    status_next[chk_idx_reg] = ST_RUNNABLE;
                end
                if (wake_idx_reg == SLOT_COUNT)
                begin
                    chk_vld_next  = 1'b0;
                    srch_idx_next = slot_inc(cur_slot_reg);
                    srch_cnt_next = SLOT_W'(1);
                    state_next    = S_SEARCH;
                end
                else
                begin
                    wake_rd       = 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = wake_idx_reg[SLOT_W-1:0];
                    wake_idx_next = wake_idx_reg + IDX_W'(1);
                end
            end
            S_SEARCH:
            begin
                // Take the first present, runnable slot after the current one
                if (sel_present && (sel_status == ST_RUNNABLE))
                begin
                    cur_slot_next = srch_idx_reg;
                    if (srch_idx_reg != '0)
                    begin
                        status_next[srch_idx_reg] = ST_RUNNING;
                    end
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (srch_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    srch_idx_next = slot_inc(srch_idx_reg);
                    srch_cnt_next = srch_cnt_reg + SLOT_W'(1);
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load when free, drop when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if ((state_reg == S_DONE) && rsp_free)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.found     = found_reg;
            rsp_next.next_slot = cur_ext[3:0];
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_slot_reg  <= '0;
            now_reg       <= '0;
            present_reg   <= TASK_SLOTS'(1);
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                status_reg[i] <= ST_RUNNABLE;
            end
            found_reg     <= 1'b0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_slot_reg  <= cur_slot_next;
            now_reg       <= now_next;
            present_reg   <= present_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Scan indexes and result payload
    always_ff @(posedge clk)
    begin
        wake_idx_reg <= wake_idx_next;
        chk_idx_reg  <= chk_idx_next;
        srch_idx_reg <= srch_idx_next;
        srch_cnt_reg <= srch_cnt_next;
        rsp_reg      <= rsp_next;
    end

endmodule

`default_nettype wire

/* design/rrss_checker.sv */
// Port-level checker for the round robin sleep scheduler, bound to the top level.
`default_nettype none

module rrss_checker
    import rrss_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
    else $error("rsp_valid dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("rsp payload changed while stalled");

    // The block is busy in the cycle after it takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("req taken while previous item still in work");

    // A new result is only loaded while the block is busy with an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared without an item in work");

endmodule

bind round_robin_sleep_scheduler rrss_checker u_rrss_checker (.*);

`default_nettype wire

/* bench/tb_round_robin_sleep_scheduler.sv */
// Self-checking testbench for the round robin sleep scheduler.
`timescale 1ns / 100ps

module tb_round_robin_sleep_scheduler;
    import rrss_pkg::*;

    localparam int N_SLOTS     = 16;
    localparam int CLK_BITS    = 32;
    localparam int N_RANDOM    = 1530;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * N_SLOTS + 8;
    localparam int N_ROWS      = 20;

    // One row of the directed sequence; typed rows carry their answer
    typedef struct packed {
        op_t        op;
        logic [3:0] slot;
        logic [15:0] secs;
        logic       typed;
        logic       found;
        logic [3:0] next_slot;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Answer attached to the item on the bus, used only for typed rows
    logic row_typed = 1'b0;
    rsp_t row_answer = '0;

    // Scheduler state as seen by the predictor
    logic        task_present [N_SLOTS];
    status_t     task_status [N_SLOTS];
    logic [CLK_BITS-1:0] task_wake [N_SLOTS];
    logic [3:0]  running_slot;
    logic [CLK_BITS-1:0] now_ms;

    rsp_t sched_answers [$];
    int errors = 0;
    int idle_cycles = 0;
    int op_count [4];
    int picks_made = 0;
    int picks_missed = 0;
    int results_seen = 0;
    logic [31:0] cycle_no = '0;

    row_t dir_rows [0:N_ROWS-1] = '{
        // after reset only slot 0 exists and it is current: nothing to pick
        '{OP_SCHED, 4'd0,  16'h0000, 1'b1, 1'b0, 4'd0},
        '{OP_TICK,  4'd15, 16'hFFFF, 1'b1, 1'b0, 4'd0},
        '{OP_ADD,   4'd15, 16'h0000, 1'b1, 1'b0, 4'd0},
        '{OP_SCHED, 4'd0,  16'h0000, 1'b1, 1'b1, 4'd15},
        // slot 0 is never marked running, so it comes back
        '{OP_SCHED, 4'd0,  16'h0000, 1'b1, 1'b1, 4'd0},
        // slot 15 stays running and is skipped
        '{OP_SCHED, 4'd0,  16'h0000, 1'b1, 1'b0, 4'd0},
        '{OP_ADD,   4'd1,  16'hFFFF, 1'b0, 1'b0, 4'd0},
        '{OP_SLEEP, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        // longest sleep, and nothing else runnable
        '{OP_SLEEP, 4'd7,  16'hFFFF, 1'b1, 1'b0, 4'd1},
        '{OP_TICK,  4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        '{OP_SCHED, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        '{OP_ADD,   4'd15, 16'h0000, 1'b0, 1'b0, 4'd0},
        '{OP_ADD,   4'd8,  16'h5555, 1'b0, 1'b0, 4'd0},
        '{OP_SCHED, 4'd10, 16'hAAAA, 1'b0, 1'b0, 4'd0},
        '{OP_SCHED, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        '{OP_SLEEP, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        // wake time equal to now does not wake
        '{OP_SCHED, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        '{OP_TICK,  4'd5,  16'h00FF, 1'b0, 1'b0, 4'd0},
        '{OP_SCHED, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
        '{OP_ADD,   4'd0,  16'hFFFF, 1'b0, 1'b0, 4'd0}
    };

    round_robin_sleep_scheduler #(
        .TASK_SLOTS (N_SLOTS),
        .TIME_BITS  (CLK_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Wake expired sleepers, then search round robin past the current slot
    function automatic logic pick_next_task();
        int idx;
        int k;
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (task_present[i] && task_status[i] == ST_SLEEP && now_ms > task_wake[i])
                task_status[i] = ST_RUNNABLE;
        end
        idx = running_slot;
        for (k = 1; k < N_SLOTS && !hit; k++)
        begin
            idx = (idx + 1) % N_SLOTS;
            if (task_present[idx] && task_status[idx] == ST_RUNNABLE)
            begin
                hit = 1'b1;
                running_slot = idx[3:0];
                if (idx != 0)
                    task_status[idx] = ST_RUNNING;
            end
        end
        return hit;
    endfunction

    // Apply one item to the scheduler state and return its result
    function automatic rsp_t advance_scheduler(input req_t r);
        rsp_t ans;
        ans.found = 1'b0;
        case (r.operation)
            OP_TICK:
                now_ms = now_ms + 1'b1;
            OP_ADD:
            begin
                task_present[r.slot] = 1'b1;
                task_status[r.slot] = ST_RUNNABLE;
            end
            OP_SLEEP:
            begin
                task_wake[running_slot] = now_ms +
                    CLK_BITS'(MS_PER_S) * CLK_BITS'(r.sleep_seconds);
                task_status[running_slot] = ST_SLEEP;
                ans.found = pick_next_task();
            end
            default:
                ans.found = pick_next_task();
        endcase
        ans.next_slot = running_slot;
        return ans;
    endfunction

    // Draw a random item: mostly short sleeps so that sleepers wake again
    function automatic req_t random_request();
        req_t r;
        int pick;
        int spread;
        pick = $urandom_range(0, 99);
        spread = $urandom_range(0, 99);
        if (pick < 25)
            r.operation = OP_TICK;
        else if (pick < 50)
            r.operation = OP_ADD;
        else if (pick < 68)
            r.operation = OP_SLEEP;
        else
            r.operation = OP_SCHED;
        r.slot = 4'($urandom_range(0, 15));
        if (spread < 60)
            r.sleep_seconds = '0;
        else if (spread < 75)
            r.sleep_seconds = 16'd1;
        else if (spread < 85)
            r.sleep_seconds = 16'($urandom_range(2, 5));
        else
            r.sleep_seconds = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // Hold one item on the bus until it is accepted
    task automatic drive_item(input req_t item, input logic typed, input rsp_t answer);
        req_valid <= 1'b1;
        req <= item;
        row_typed <= typed;
        row_answer <= answer;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Check results, then record accepted items and their predicted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (sched_answers.size() == 0)
                    flag_mismatch($sformatf("unexpected result found=%0b slot=%0d",
                                            rsp.found, rsp.next_slot));
                else
                begin
                    if (rsp.found !== sched_answers[0].found)
                        flag_mismatch($sformatf("found %0b, want %0b",
                                                rsp.found, sched_answers[0].found));
                    if (rsp.next_slot !== sched_answers[0].next_slot)
                        flag_mismatch($sformatf("next_slot %0d, want %0d",
                                                rsp.next_slot, sched_answers[0].next_slot));
                    void'(sched_answers.pop_front());
                end
            end
            if (req_valid && !req_stall)
            begin
                rsp_t predicted;
                predicted = advance_scheduler(req);
                op_count[req.operation]++;
                if (req.operation == OP_SLEEP || req.operation == OP_SCHED)
                begin
                    if (predicted.found)
                        picks_made++;
                    else
                        picks_missed++;
                end
                sched_answers.push_back(row_typed ? row_answer : predicted);
            end
        end
    end

    // Receiver stall pattern: free, light, heavy and periodic phases
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        case (cycle_no[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (cycle_no[2:0] < 3'd5);
        endcase
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("round_robin_sleep_scheduler verification failed");
            $finish;
        end
    end

    initial
    begin
        int burst_left;
        int gap;
        req_t item;
        rsp_t answer;

        // Seed the predictor with the reset state
        for (int i = 0; i < N_SLOTS; i++)
        begin
            task_present[i] = (i == 0);
            task_status[i] = ST_RUNNABLE;
            task_wake[i] = '0;
        end
        running_slot = '0;
        now_ms = '0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back
        for (int n = 0; n < N_ROWS; n++)
        begin
            item.operation = dir_rows[n].op;
            item.slot = dir_rows[n].slot;
            item.sleep_seconds = dir_rows[n].secs;
            answer.found = dir_rows[n].found;
            answer.next_slot = dir_rows[n].next_slot;
            drive_item(item, dir_rows[n].typed, answer);
        end

        // Random items in bursts with random gaps between them
        burst_left = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            drive_item(random_request(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sched_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sched_answers.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", sched_answers.size()));

        $display("Items: %0d tick, %0d add, %0d sleep, %0d schedule; %0d results checked",
                 op_count[OP_TICK], op_count[OP_ADD], op_count[OP_SLEEP],
                 op_count[OP_SCHED], results_seen);
        $display("Scheduling passes: %0d picked a task, %0d found none; %0d mismatches",
                 picks_made, picks_missed, errors);
        if (errors == 0)
            $display("round_robin_sleep_scheduler verification clean");
        else
            $display("round_robin_sleep_scheduler verification failed");
        $finish;
    end

endmodule
